// File: rtl/qmd_pkg.sv
// ----------------------------------------------------------------------------
// qmd_pkg
// shared types and codes for the queue with middle delete
// ----------------------------------------------------------------------------
package qmd_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  // operation codes carried on the input tuser
  localparam op_t OP_ENQ    = 2'd0;
  localparam op_t OP_DEQ    = 2'd1;
  localparam op_t OP_DELMID = 2'd2;

  // result status codes
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // payload widths fixed by the item format
  localparam int unsigned WORD_W = 32;

endpackage

// File: rtl/queue_with_middle_delete.sv
// ----------------------------------------------------------------------------
// queue_with_middle_delete
// fifo of signed words kept as a doubly linked list in a node pool, which
// also tracks its middle entry and can delete it
// ----------------------------------------------------------------------------
// sequencing: a beat is taken only in idle, so one operation runs at a time;
//   refusal or unused op: mid, done; enqueue, dequeue: op, move if needed, mid,
//   done; delete middle: op, move and link unless emptied, mid, done; the steps
//   follow from the single link write port and registered reads of both memories
// reset: synchronous active-low rst_n empties the queue; the pool memories are
//   not cleared, nodes are only read after they have been written
// ----------------------------------------------------------------------------
module queue_with_middle_delete #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW        = $clog2(CAPACITY + 1),
  localparam int OUT_W     = ((67 + CW + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,   // value[31:0]
  input  qmd_pkg::op_t        in_tuser,   // op[1:0]
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata   // status[1:0], removed_value[33:2],
                                          // middle_valid[34], middle_value[66:35],
                                          // count[66+CW:67], zero pad above
);
  import qmd_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a beat, issue first reads
  localparam logic [2:0] S_OP   = 3'd1;  // main update with node read data
  localparam logic [2:0] S_MOVE = 3'd2;  // second link write / middle step
  localparam logic [2:0] S_LINK = 3'd3;  // third link write on delete middle
  localparam logic [2:0] S_MID  = 3'd4;  // read the middle word
  localparam logic [2:0] S_DONE = 3'd5;  // load the output register

  // node pool memories
  logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
  logic [2*IW-1:0]       link_mem [CAPACITY];  // {prev, next}

  logic [2:0]            state_r, state_nxt;
  logic [IW-1:0]         front_r, front_nxt;
  logic [IW-1:0]         back_r, back_nxt;
  logic [IW-1:0]         mid_r, mid_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;       // fresh nodes handed out so far
  logic [IW-1:0]         fhead_r, fhead_nxt;     // head of recycled node chain
  op_t                   op_r, op_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  status_t               stat_r, stat_nxt;
  logic                  odd_r, odd_nxt;
  logic [IW-1:0]         node_r, node_nxt;       // new node on enqueue
  logic [IW-1:0]         nx_r, nx_nxt;
  logic [IW-1:0]         pv_r, pv_nxt;
  logic                  at_front_r, at_front_nxt;
  logic                  at_back_r, at_back_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  // memory ports
  logic [IW-1:0]         dt_raddr, dt_waddr;
  logic                  dt_we;
  logic [DATA_WIDTH-1:0] dt_wdata, dt_rdata;
  logic [IW-1:0]         lk_raddr, lk_waddr;
  logic                  lk_we_next, lk_we_prev;
  logic [IW-1:0]         lk_wnext, lk_wprev;
  logic [2*IW-1:0]       lk_rdata;
  logic [IW-1:0]         rd_next, rd_prev;

  logic                  in_acc;
  logic                  out_free;
  logic                  had_one;
  logic [IW-1:0]         alloc;
  logic [63:0]           in_wide, rem_wide, mid_wide;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rd_next = lk_rdata[IW-1:0];
  assign rd_prev = lk_rdata[2*IW-1:IW];
  assign had_one = (count_r == CW'(1));

  // first reads go out with the accepted beat, later ones follow the middle
  assign lk_raddr = (state_r != S_IDLE)  ? mid_r :
                    (in_tuser == OP_ENQ) ? fhead_r :
                    (in_tuser == OP_DEQ) ? front_r : mid_r;
  assign dt_raddr = (state_r == S_IDLE && in_tuser == OP_DEQ) ? front_r : mid_r;

  // fresh nodes first, then recycled ones
  assign alloc = (fill_r < CW'(CAPACITY)) ? fill_r[IW-1:0] : fhead_r;

  always_ff @(posedge clk) begin
    if (dt_we) begin
      data_mem[dt_waddr] <= dt_wdata;
    end
    dt_rdata <= data_mem[dt_raddr];
  end

  always_ff @(posedge clk) begin
    if (lk_we_next) begin
      link_mem[lk_waddr][IW-1:0] <= lk_wnext;
    end
    if (lk_we_prev) begin
      link_mem[lk_waddr][2*IW-1:IW] <= lk_wprev;
    end
    lk_rdata <= link_mem[lk_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    mid_nxt       = mid_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    fhead_nxt     = fhead_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    stat_nxt      = stat_r;
    odd_nxt       = odd_r;
    node_nxt      = node_r;
    nx_nxt        = nx_r;
    pv_nxt        = pv_r;
    at_front_nxt  = at_front_r;
    at_back_nxt   = at_back_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    dt_we         = 1'b0;
    dt_waddr      = alloc;
    dt_wdata      = val_r;
    lk_we_next    = 1'b0;
    lk_we_prev    = 1'b0;
    lk_waddr      = alloc;
    lk_wnext      = '0;
    lk_wprev      = back_r;
    in_wide       = 64'(in_tdata);
    rem_wide      = 64'(rem_r);
    mid_wide      = 64'(dt_rdata);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_tuser;
          val_nxt  = in_wide[DATA_WIDTH-1:0];
          rem_nxt  = '0;
          stat_nxt = ST_DONE;
          odd_nxt  = count_r[0];
          state_nxt = S_OP;
          case (in_tuser)
            OP_ENQ: begin
              if (count_r == CW'(CAPACITY)) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_MID;
              end
            end
            OP_DEQ, OP_DELMID: begin
              if (count_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_MID;
              end
            end
            default: begin
              state_nxt = S_MID;
            end
          endcase
        end
      end

      S_OP: begin
        case (op_r)
          OP_ENQ: begin
            // new node goes in behind the back
            dt_we      = 1'b1;
            lk_we_next = 1'b1;
            lk_we_prev = 1'b1;
            node_nxt   = alloc;
            if (fill_r < CW'(CAPACITY)) begin
              fill_nxt = fill_r + CW'(1);
            end else begin
              fhead_nxt = rd_next;
            end
            if (count_r == '0) begin
              front_nxt = alloc;
              back_nxt  = alloc;
              mid_nxt   = alloc;
              count_nxt = CW'(1);
              state_nxt = S_MID;
            end else begin
              state_nxt = S_MOVE;
            end
          end
          OP_DEQ: begin
            // front node returns to the recycle chain
            rem_nxt    = dt_rdata;
            lk_we_next = 1'b1;
            lk_waddr   = front_r;
            lk_wnext   = fhead_r;
            fhead_nxt  = front_r;
            if (had_one) begin
              front_nxt = '0;
              back_nxt  = '0;
              mid_nxt   = '0;
              count_nxt = '0;
              state_nxt = S_MID;
            end else begin
              front_nxt = rd_next;
              count_nxt = count_r - CW'(1);
              state_nxt = odd_r ? S_MOVE : S_MID;
            end
          end
          default: begin
            // delete middle: unhook the middle node
            rem_nxt      = dt_rdata;
            lk_we_next   = 1'b1;
            lk_waddr     = mid_r;
            lk_wnext     = fhead_r;
            fhead_nxt    = mid_r;
            nx_nxt       = rd_next;
            pv_nxt       = rd_prev;
            at_front_nxt = (mid_r == front_r);
            at_back_nxt  = (mid_r == back_r);
            if (had_one) begin
              front_nxt = '0;
              back_nxt  = '0;
              mid_nxt   = '0;
              count_nxt = '0;
              state_nxt = S_MID;
            end else begin
              if (mid_r == front_r) begin
                front_nxt = rd_next;
              end
              if (mid_r == back_r) begin
                back_nxt = rd_prev;
              end
              mid_nxt   = odd_r ? rd_next : rd_prev;
              count_nxt = count_r - CW'(1);
              state_nxt = S_MOVE;
            end
          end
        endcase
      end

      S_MOVE: begin
        case (op_r)
          OP_ENQ: begin
            // old back points at the new node
            lk_we_next = 1'b1;
            lk_waddr   = back_r;
            lk_wnext   = node_r;
            back_nxt   = node_r;
            count_nxt  = count_r + CW'(1);
            if (odd_r) begin
              mid_nxt = had_one ? node_r : rd_next;
            end
            state_nxt = S_MID;
          end
          OP_DEQ: begin
            mid_nxt   = rd_next;
            state_nxt = S_MID;
          end
          default: begin
            if (!at_back_r) begin
              lk_we_prev = 1'b1;
              lk_waddr   = nx_r;
              lk_wprev   = pv_r;
            end
            state_nxt = S_LINK;
          end
        endcase
      end

      S_LINK: begin
        if (!at_front_r) begin
          lk_we_next = 1'b1;
          lk_waddr   = pv_r;
          lk_wnext   = nx_r;
        end
        state_nxt = S_MID;
      end

      S_MID: begin
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[1:0]   = stat_r;
          out_data_nxt[33:2]  = rem_wide[31:0];
          out_data_nxt[34]    = (count_r != '0);
          out_data_nxt[66:35] = (count_r != '0) ? mid_wide[31:0] : 32'd0;
          out_data_nxt[66+CW:67] = count_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      mid_r       <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      fhead_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      mid_r       <= mid_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      fhead_r     <= fhead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    rem_r      <= rem_nxt;
    stat_r     <= stat_nxt;
    odd_r      <= odd_nxt;
    node_r     <= node_nxt;
    nx_r       <= nx_nxt;
    pv_r       <= pv_nxt;
    at_front_r <= at_front_nxt;
    at_back_r  <= at_back_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CW'(CAPACITY)) && (fill_r <= CW'(CAPACITY)))
    else $error("entry or fill count beyond capacity");

  a_count_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fill_r)
    else $error("more entries than nodes ever handed out");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after taking a beat");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded on leaving the done state");

  a_mid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[34] == (out_data_r[66+CW:67] != '0)))
    else $error("middle flag disagrees with reported count");
`endif

endmodule
